// File: hdl/affine_point_transform_top_assert.svh
// Assertion macros for the affine point transform block.
// Used by affine_point_transform_top; expects signals clk and arst_n in scope.
`ifndef AFFINE_POINT_TRANSFORM_TOP_ASSERT_SVH
`define AFFINE_POINT_TRANSFORM_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define APT_ASSERT_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define APT_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// File: hdl/apt_pkg.sv
// Shared types, widths, codes and helper functions of the affine point transform.
// No dependencies; every other file of the block but the assertion header imports this package.
package apt_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int FIELD_W   = 32;
	localparam int CMD_W     = 3;
	localparam int CFG_REGS  = 6;
	localparam int CFG_W     = 64;
	localparam int HALF_W    = CFG_W / 2;
	localparam int CFG_IDX_W = $clog2(CFG_REGS);

	// Datapath widths. VW holds a sum or difference of two words, OPW the
	// multiplier A operand, BW a matrix entry or its magnitude.
	localparam int VW   = WORD_BITS + 1;
	localparam int OPW  = WORD_BITS + 2;
	localparam int BW   = WORD_BITS + 1;
	localparam int MULW = OPW + BW;
	localparam int PRW  = MULW - FRAC_BITS;
	localparam int ACCW = ((PRW > WORD_BITS) ? PRW : WORD_BITS) + 2;
	localparam int RW   = ACCW + 1;

	typedef enum logic [CMD_W-1:0] {
		CMD_XFORM,
		CMD_INV_XFORM,
		CMD_ROTATE,
		CMD_INV_ROTATE,
		CMD_BOX
	} cmd_e;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW0_LO,
		REG_ROW0_HI,
		REG_ROW1_LO,
		REG_ROW1_HI,
		REG_ROW2_LO,
		REG_ROW2_HI
	} cfg_reg_e;

	localparam logic [CFG_W-1:0] RST_ROW0_LO = 64'h0000_0000_0001_0000;
	localparam logic [CFG_W-1:0] RST_ROW0_HI = 64'h0000_0000_0000_0000;
	localparam logic [CFG_W-1:0] RST_ROW1_LO = 64'h0001_0000_0000_0000;
	localparam logic [CFG_W-1:0] RST_ROW1_HI = 64'h0000_0000_0000_0000;
	localparam logic [CFG_W-1:0] RST_ROW2_LO = 64'h0000_0000_0000_0000;
	localparam logic [CFG_W-1:0] RST_ROW2_HI = 64'h0000_0000_0001_0000;

	localparam logic signed [RW-1:0] SAT_HI =
		signed'({{(RW-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}});
	localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

	typedef logic [CFG_REGS-1:0][CFG_W-1:0] cfg_regs_t;

	typedef struct packed {
		logic [CMD_W-1:0]          command;
		logic signed [FIELD_W-1:0] in_x;
		logic signed [FIELD_W-1:0] in_y;
		logic signed [FIELD_W-1:0] in_z;
		logic signed [FIELD_W-1:0] box_max_x;
		logic signed [FIELD_W-1:0] box_max_y;
		logic signed [FIELD_W-1:0] box_max_z;
	} point_cmd_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] res_x;
		logic signed [FIELD_W-1:0] res_y;
		logic signed [FIELD_W-1:0] res_z;
		logic signed [FIELD_W-1:0] world_max_x;
		logic signed [FIELD_W-1:0] world_max_y;
		logic signed [FIELD_W-1:0] world_max_z;
		logic                      saturated;
	} point_res_t;

	// Multiplier operands: a[j] times b[i][j] and a2[j] times b2[i][j].
	typedef struct packed {
		logic [CMD_W-1:0]           cmd;
		logic [2:0][OPW-1:0]        a;
		logic [2:0][2:0][BW-1:0]    b;
		logic [2:0][OPW-1:0]        a2;
		logic [2:0][2:0][BW-1:0]    b2;
	} ops_t;

	// Scaled products, already shifted down by the fraction bits.
	typedef struct packed {
		logic [CMD_W-1:0]           cmd;
		logic [2:0][2:0][PRW-1:0]   p;
		logic [2:0][2:0][PRW-1:0]   p2;
	} prod_t;

	typedef struct packed {
		logic adv;
		logic skid_full;
	} obuf_stat_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] val;
		logic                        clip;
	} sat_t;

	// Matrix entry (row, col); col 3 is the origin column.
	function automatic logic signed [WORD_BITS-1:0] m_entry(input cfg_regs_t cfg,
			input int unsigned row, input int unsigned col);
		logic [CFG_W-1:0]  w;
		logic [HALF_W-1:0] half;
		w = cfg[CFG_IDX_W'(row * 2 + (col >> 1))];
		half = col[0] ? w[CFG_W-1:HALF_W] : w[HALF_W-1:0];
		return signed'(half[WORD_BITS-1:0]);
	endfunction

	function automatic sat_t sat_word(input logic signed [RW-1:0] v);
		sat_t s;
		s.clip = 1'b0;
		s.val  = signed'(v[WORD_BITS-1:0]);
		if (v > SAT_HI) begin
			s.val  = signed'(SAT_HI[WORD_BITS-1:0]);
			s.clip = 1'b1;
		end else if (v < SAT_LO) begin
			s.val  = signed'(SAT_LO[WORD_BITS-1:0]);
			s.clip = 1'b1;
		end
		return s;
	endfunction

	function automatic logic signed [FIELD_W-1:0] to_field(
			input logic signed [WORD_BITS-1:0] v);
		return FIELD_W'(v);
	endfunction

endpackage

// File: hdl/apt_prep.sv
// Operand preparation, pipeline stages 1 and 2 of the affine point transform.
// Depends on apt_pkg for widths, command codes and the matrix entry function.
module apt_prep import apt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic       in_vld,
	input  point_cmd_t in_data,
	input  cfg_regs_t  cfg,
	output logic       vld_s2,
	output ops_t       ops_s2
);

	logic signed [WORD_BITS-1:0] pa [3];
	logic signed [WORD_BITS-1:0] pb [3];
	logic signed [VW-1:0]        v_d [3];
	logic signed [VW-1:0]        sum_d [3];

	logic                        vld_s1;
	logic [CMD_W-1:0]            cmd_s1;
	logic signed [VW-1:0]        v_s1 [3];
	logic signed [VW-1:0]        sum_s1 [3];
	logic signed [WORD_BITS-1:0] b_s1 [3];

	logic signed [WORD_BITS-1:0] ctr [3];
	logic signed [VW-1:0]        ext_p [3];
	logic signed [VW-1:0]        ext_n [3];
	logic [VW-1:0]               ext_abs [3];
	logic signed [WORD_BITS-1:0] mij [3][3];
	logic                        is_box;
	logic                        is_trans;
	ops_t                        ops_d;

	// Stage 1: origin subtraction for the inverse transform and the corner sum.
	always_comb begin
		pa[0] = signed'(in_data.in_x[WORD_BITS-1:0]);
		pa[1] = signed'(in_data.in_y[WORD_BITS-1:0]);
		pa[2] = signed'(in_data.in_z[WORD_BITS-1:0]);
		pb[0] = signed'(in_data.box_max_x[WORD_BITS-1:0]);
		pb[1] = signed'(in_data.box_max_y[WORD_BITS-1:0]);
		pb[2] = signed'(in_data.box_max_z[WORD_BITS-1:0]);
		for (int j = 0; j < 3; j++) begin
			v_d[j] = (in_data.command == CMD_INV_XFORM) ?
				VW'(pa[j]) - VW'(m_entry(cfg, j, 3)) : VW'(pa[j]);
			sum_d[j] = VW'(pa[j]) + VW'(pb[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= in_data.command;
			for (int j = 0; j < 3; j++) begin
				v_s1[j]   <= v_d[j];
				sum_s1[j] <= sum_d[j];
				b_s1[j]   <= pb[j];
			end
		end
	end

	// Stage 2: box center and extent magnitude, operand selection per lane.
	always_comb begin
		is_box   = (cmd_s1 == CMD_BOX);
		is_trans = (cmd_s1 == CMD_INV_XFORM) || (cmd_s1 == CMD_INV_ROTATE);
		ops_d.cmd = cmd_s1;
		for (int j = 0; j < 3; j++) begin
			ctr[j]     = signed'(sum_s1[j][VW-1:1]);
			ext_p[j]   = VW'(b_s1[j]) - VW'(ctr[j]);
			ext_n[j]   = VW'(ctr[j]) - VW'(b_s1[j]);
			ext_abs[j] = ext_p[j][VW-1] ? ext_n[j] : ext_p[j];
			ops_d.a[j]  = is_box ? OPW'(ctr[j]) : OPW'(v_s1[j]);
			ops_d.a2[j] = is_box ? OPW'({1'b0, ext_abs[j]}) : '0;
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				mij[i][j] = m_entry(cfg, i, j);
			end
		end
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				ops_d.b[i][j]  = is_trans ? BW'(mij[j][i]) : BW'(mij[i][j]);
				ops_d.b2[i][j] = mij[i][j][WORD_BITS-1] ?
					-BW'(mij[i][j]) : BW'(mij[i][j]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ops_s2 <= ops_d;
		end
	end

endmodule

// File: hdl/apt_mul.sv
// Multiplier array, pipeline stage 3: eighteen products scaled by the fraction bits.
// Depends on apt_pkg for operand and product types.
module apt_mul import apt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  adv,
	input  logic  vld_s2,
	input  ops_t  ops_s2,
	output logic  vld_s3,
	output prod_t prod_s3
);

	logic signed [MULW-1:0] full  [3][3];
	logic signed [MULW-1:0] full2 [3][3];
	prod_t                  prod_d;

	// Dropping the low fraction bits of a two's complement product floors it.
	always_comb begin
		prod_d.cmd = ops_s2.cmd;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				full[i][j]  = signed'(ops_s2.a[j])  * signed'(ops_s2.b[i][j]);
				full2[i][j] = signed'(ops_s2.a2[j]) * signed'(ops_s2.b2[i][j]);
				prod_d.p[i][j]  = full[i][j][FRAC_BITS +: PRW];
				prod_d.p2[i][j] = full2[i][j][FRAC_BITS +: PRW];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3 <= prod_d;
		end
	end

endmodule

// File: hdl/apt_acc.sv
// Row sums, box corners and saturation, pipeline stages 4 and 5.
// Depends on apt_pkg for types, codes and the saturation function.
module apt_acc import apt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic       vld_s3,
	input  prod_t      prod_s3,
	input  cfg_regs_t  cfg,
	output logic       vld_s5,
	output point_res_t res_s5
);

	logic signed [ACCW-1:0] org_add [3];
	logic signed [ACCW-1:0] c_d [3];
	logic signed [ACCW-1:0] e_d [3];
	logic                   add_org;

	logic                   vld_s4;
	logic [CMD_W-1:0]       cmd_s4;
	logic signed [ACCW-1:0] c_s4 [3];
	logic signed [ACCW-1:0] e_s4 [3];

	sat_t                   lo_sat [3];
	sat_t                   hi_sat [3];
	logic                   known;
	logic                   is_box;
	point_res_t             res_d;

	// Stage 4: sum each row's products, adding the origin for XFORM and BOX; e is zero unless box.
	always_comb begin
		add_org = (prod_s3.cmd == CMD_XFORM) || (prod_s3.cmd == CMD_BOX);
		for (int i = 0; i < 3; i++) begin
			org_add[i] = add_org ? ACCW'(m_entry(cfg, i, 3)) : '0;
			c_d[i] = ACCW'(signed'(prod_s3.p[i][0])) + ACCW'(signed'(prod_s3.p[i][1]))
				+ ACCW'(signed'(prod_s3.p[i][2])) + org_add[i];
			e_d[i] = ACCW'(signed'(prod_s3.p2[i][0])) + ACCW'(signed'(prod_s3.p2[i][1]))
				+ ACCW'(signed'(prod_s3.p2[i][2]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s4 <= prod_s3.cmd;
			for (int i = 0; i < 3; i++) begin
				c_s4[i] <= c_d[i];
				e_s4[i] <= e_d[i];
			end
		end
	end

	// Stage 5: corners, clamping, and zeroing for unused command codes.
	always_comb begin
		known  = cmd_s4 inside {[CMD_XFORM:CMD_BOX]};
		is_box = (cmd_s4 == CMD_BOX);
		for (int i = 0; i < 3; i++) begin
			lo_sat[i] = sat_word(RW'(c_s4[i]) - RW'(e_s4[i]));
			hi_sat[i] = sat_word(RW'(c_s4[i]) + RW'(e_s4[i]));
		end
		res_d = '0;
		if (known) begin
			res_d.res_x = to_field(lo_sat[0].val);
			res_d.res_y = to_field(lo_sat[1].val);
			res_d.res_z = to_field(lo_sat[2].val);
			res_d.saturated = lo_sat[0].clip | lo_sat[1].clip | lo_sat[2].clip;
			if (is_box) begin
				res_d.world_max_x = to_field(hi_sat[0].val);
				res_d.world_max_y = to_field(hi_sat[1].val);
				res_d.world_max_z = to_field(hi_sat[2].val);
				res_d.saturated = res_d.saturated | hi_sat[0].clip | hi_sat[1].clip
					| hi_sat[2].clip;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s5 <= res_d;
		end
	end

endmodule

// File: hdl/apt_obuf.sv
// Output register with a one-beat skid buffer; it sets the pipeline advance.
// Depends on apt_pkg for the result and status types.
module apt_obuf import apt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       vld_s5,
	input  point_res_t res_s5,
	input  logic       res_ready,
	output logic       res_valid,
	output point_res_t res_data,
	output obuf_stat_t stat
);

	logic       out_vld_q;
	logic       skid_vld_q;
	point_res_t out_q;
	point_res_t skid_q;
	logic       to_out;
	logic       to_skid;
	logic       skid_drain;

	// The pipeline moves whenever the skid is empty, so a beat leaving the
	// last stage always finds room in the output register or in the skid.
	always_comb begin
		stat.adv       = !skid_vld_q;
		stat.skid_full = skid_vld_q;
		skid_drain     = skid_vld_q && res_ready;
		to_out         = !skid_vld_q && vld_s5 && (!out_vld_q || res_ready);
		to_skid        = !skid_vld_q && vld_s5 && out_vld_q && !res_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else begin
			if (skid_drain) begin
				skid_vld_q <= 1'b0;
			end else if (to_skid) begin
				skid_vld_q <= 1'b1;
			end
			if (to_out) begin
				out_vld_q <= 1'b1;
			end else if (!skid_vld_q && res_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_drain) begin
			out_q <= skid_q;
		end else if (to_out) begin
			out_q <= res_s5;
		end
		if (to_skid) begin
			skid_q <= res_s5;
		end
	end

	assign res_valid = out_vld_q;
	assign res_data  = out_q;

endmodule

// File: hdl/affine_point_transform_top.sv
// Top level of the affine point transform: configuration registers and pipeline.
// Depends on apt_pkg, apt_prep, apt_mul, apt_acc, apt_obuf and the assertion header.
//
// Usage:
// The command channel (cmd_valid, cmd_ready, cmd_data) takes one beat per
// cycle while cmd_ready is high: a command code with a vector, or with the
// minimum and maximum corners of a box. The result channel (res_valid,
// res_ready, res_data) returns exactly one beat per command, in order. Each
// command code other than the five defined ones yields an all-zero result.
// A beat passes through pipeline stages 1 to 5 and the output register to
// res_valid, and throughput is one beat per cycle for as long as the receiver
// keeps res_ready high. The matrix lives in six 64-bit registers written
// through cfg_we, cfg_index and cfg_wdata; writes take effect at once and
// are meant for times when no beat is in flight. Reset (arst_n low) loads
// the identity matrix and empties the pipeline and the output buffer.
// When the receiver stalls, the output register holds its beat and a skid
// register catches the next one; in the cycle after that, cmd_ready drops and
// the whole five-stage pipeline freezes in place. cmd_ready comes from a flop.
`include "affine_point_transform_top_assert.svh"

module affine_point_transform_top import apt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  point_cmd_t           cmd_data,
	output logic                 res_valid,
	input  logic                 res_ready,
	output point_res_t           res_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	cfg_regs_t  cfg_q;
	obuf_stat_t stat;
	logic       vld_s2;
	logic       vld_s3;
	logic       vld_s5;
	ops_t       ops_s2;
	prod_t      prod_s3;
	point_res_t res_s5;

	// Matrix registers. Writes to an index past the last register are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[REG_ROW0_LO] <= RST_ROW0_LO;
			cfg_q[REG_ROW0_HI] <= RST_ROW0_HI;
			cfg_q[REG_ROW1_LO] <= RST_ROW1_LO;
			cfg_q[REG_ROW1_HI] <= RST_ROW1_HI;
			cfg_q[REG_ROW2_LO] <= RST_ROW2_LO;
			cfg_q[REG_ROW2_HI] <= RST_ROW2_HI;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW0_LO: cfg_q[REG_ROW0_LO] <= cfg_wdata;
				REG_ROW0_HI: cfg_q[REG_ROW0_HI] <= cfg_wdata;
				REG_ROW1_LO: cfg_q[REG_ROW1_LO] <= cfg_wdata;
				REG_ROW1_HI: cfg_q[REG_ROW1_HI] <= cfg_wdata;
				REG_ROW2_LO: cfg_q[REG_ROW2_LO] <= cfg_wdata;
				REG_ROW2_HI: cfg_q[REG_ROW2_HI] <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// The command channel is open exactly when the pipeline advances.
	assign cmd_ready = stat.adv;

	apt_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (stat.adv),
		.in_vld  (cmd_valid),
		.in_data (cmd_data),
		.cfg     (cfg_q),
		.vld_s2  (vld_s2),
		.ops_s2  (ops_s2)
	);

	apt_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (stat.adv),
		.vld_s2  (vld_s2),
		.ops_s2  (ops_s2),
		.vld_s3  (vld_s3),
		.prod_s3 (prod_s3)
	);

	apt_acc u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (stat.adv),
		.vld_s3  (vld_s3),
		.prod_s3 (prod_s3),
		.cfg     (cfg_q),
		.vld_s5  (vld_s5),
		.res_s5  (res_s5)
	);

	apt_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld_s5    (vld_s5),
		.res_s5    (res_s5),
		.res_ready (res_ready),
		.res_valid (res_valid),
		.res_data  (res_data),
		.stat      (stat)
	);

	// The skid only fills behind a beat that is already on the output.
	`APT_ASSERT_NOW(a_skid_behind_out, stat.skid_full, res_valid, "skid full without output beat")
	// A taken output beat always frees the skid, so the input reopens next cycle.
	`APT_ASSERT_NEXT(a_ready_recovers, !cmd_ready && res_ready, cmd_ready, "cmd_ready stuck low")
	// A frozen pipeline keeps the beat in its last stage.
	`APT_ASSERT_NEXT(a_stall_holds, vld_s5 && !stat.adv, vld_s5, "last stage beat lost in stall")

endmodule

// File: test/affine_point_transform_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for affine_point_transform_top: directed and random command beats.
// Depends on apt_pkg for the beat structs, the command codes and the register indexes.
module affine_point_transform_top_tb;
	import apt_pkg::*;

	// Products and sums are worked out exactly at this width. The largest
	// product is about 2^33 times 2^32, so 96 bits leave plenty of headroom.
	typedef logic signed [95:0] wide_t;

	// How a random 32-bit word is drawn: a small Q16.16 value, any word at
	// all, one of a handful of corner values, or a weighted mix of the three.
	typedef enum int {
		VAL_SMALL,
		VAL_FULL,
		VAL_EXTREME,
		VAL_MIXED
	} value_kind_e;

	localparam int ORIGIN_COL = 3;
	localparam int STALL_LIMIT = 2000;
	// Cycles to wait after the last result before the verdict.
	localparam int DRAIN_CYCLES = 10;
	localparam int PHASE_BEATS = 140;
	localparam int PHASES = 8;
	localparam int FINAL_BEATS = 130;
	localparam int PRINT_CAP = 40;

	localparam logic [31:0] Q_ONE = 32'h0001_0000;
	localparam logic [31:0] W_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] W_MIN = 32'h8000_0000;

	localparam wide_t WORD_TOP = (96'sd1 <<< (WORD_BITS - 1)) - 96'sd1;
	localparam wide_t WORD_BOT = -WORD_TOP - 96'sd1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	point_cmd_t cmd_data = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	point_res_t res_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	// The testbench's own copy of the six matrix registers. It is changed only
	// while no beat is in flight, so every prediction sees the matrix that the
	// block uses for that beat.
	cfg_regs_t matrix_regs = '0;

	// Expected result beats, oldest first.
	point_res_t pending_results[$];

	int mismatch_count = 0;
	int stuck_cycles = 0;

	// Chances, in percent, that the sender pauses before a beat and that the
	// receiver stalls.
	int gap_pct = 25;
	int stall_pct = 25;

	affine_point_transform_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_data  (cmd_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// Matrix entry at (row, col), sign-extended; column 3 is the origin.
	function automatic wide_t matrix_at(int unsigned row, int unsigned col);
		logic [CFG_W-1:0] pair;
		logic signed [31:0] half;
		wide_t ext;
		pair = matrix_regs[row * 2 + col / 2];
		half = (col % 2 == 1) ? pair[63:32] : pair[31:0];
		ext = half;
		return ext;
	endfunction

	// Q16.16 product, truncated toward minus infinity.
	function automatic wide_t qmul(wide_t a, wide_t b);
		return (a * b) >>> FRAC_BITS;
	endfunction

	function automatic wide_t magnitude(wide_t x);
		return (x < 0) ? -x : x;
	endfunction

	// Clamp to a signed 32-bit word; bit 32 tells whether clamping happened.
	function automatic logic [32:0] clamp_word(wide_t v);
		if (v > WORD_TOP)
			return {1'b1, WORD_TOP[31:0]};
		if (v < WORD_BOT)
			return {1'b1, WORD_BOT[31:0]};
		return {1'b0, v[31:0]};
	endfunction

	// Expected result beat for one command beat under the current matrix.
	function automatic point_res_t predict_point(point_cmd_t c);
		wide_t src [3];
		wide_t far [3];
		wide_t vec [3];
		wide_t ctr [3];
		wide_t ext [3];
		wide_t low_r [3];
		wide_t high_r [3];
		wide_t sum, acc_c, acc_e;
		logic [32:0] sat [6];
		point_res_t r;
		src[0] = $signed(c.in_x);
		src[1] = $signed(c.in_y);
		src[2] = $signed(c.in_z);
		far[0] = $signed(c.box_max_x);
		far[1] = $signed(c.box_max_y);
		far[2] = $signed(c.box_max_z);
		for (int i = 0; i < 3; i++) begin
			low_r[i] = '0;
			high_r[i] = '0;
		end
		if (c.command <= CMD_INV_ROTATE) begin
			// The inverse transform takes the origin off first; both inverse
			// forms then multiply by the transpose of the rotation part.
			for (int i = 0; i < 3; i++)
				vec[i] = (c.command == CMD_INV_XFORM) ? src[i] - matrix_at(i, ORIGIN_COL) : src[i];
			for (int i = 0; i < 3; i++) begin
				acc_c = '0;
				for (int j = 0; j < 3; j++) begin
					if (c.command == CMD_INV_XFORM || c.command == CMD_INV_ROTATE)
						acc_c += qmul(vec[j], matrix_at(j, i));
					else
						acc_c += qmul(vec[j], matrix_at(i, j));
				end
				if (c.command == CMD_XFORM)
					acc_c += matrix_at(i, ORIGIN_COL);
				low_r[i] = acc_c;
			end
		end else if (c.command == CMD_BOX) begin
			// Center rounds down; an inverted box gives negative extents,
			// which only ever enter through their magnitude.
			for (int i = 0; i < 3; i++) begin
				sum = src[i] + far[i];
				ctr[i] = sum >>> 1;
				ext[i] = far[i] - ctr[i];
			end
			for (int i = 0; i < 3; i++) begin
				acc_c = matrix_at(i, ORIGIN_COL);
				acc_e = '0;
				for (int j = 0; j < 3; j++) begin
					acc_c += qmul(ctr[j], matrix_at(i, j));
					acc_e += qmul(magnitude(ext[j]), magnitude(matrix_at(i, j)));
				end
				low_r[i] = acc_c - acc_e;
				high_r[i] = acc_c + acc_e;
			end
		end
		// Unused command codes leave everything zero, flag included.
		r = '0;
		if (c.command <= CMD_BOX) begin
			for (int i = 0; i < 3; i++) begin
				sat[i] = clamp_word(low_r[i]);
				sat[i + 3] = clamp_word(high_r[i]);
			end
			r.res_x = sat[0][31:0];
			r.res_y = sat[1][31:0];
			r.res_z = sat[2][31:0];
			r.world_max_x = sat[3][31:0];
			r.world_max_y = sat[4][31:0];
			r.world_max_z = sat[5][31:0];
			r.saturated = sat[0][32] | sat[1][32] | sat[2][32] |
				sat[3][32] | sat[4][32] | sat[5][32];
		end
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic logic [31:0] pick_word(value_kind_e kind);
		logic [31:0] raw;
		value_kind_e k;
		int roll;
		raw = $urandom;
		k = kind;
		if (k == VAL_MIXED) begin
			roll = $urandom_range(0, 9);
			k = (roll < 5) ? VAL_SMALL : (roll < 8) ? VAL_FULL : VAL_EXTREME;
		end
		case (k)
			VAL_SMALL: begin
				return 32'($signed(raw) >>> $urandom_range(7, 24));
			end
			VAL_FULL: begin
				return raw;
			end
			default: begin
				case (raw[2:0])
					3'd0: return W_MAX;
					3'd1: return W_MIN;
					3'd2: return 32'h0;
					3'd3: return 32'hFFFF_FFFF;
					3'd4: return Q_ONE;
					3'd5: return -Q_ONE;
					3'd6: return 32'h1;
					default: return W_MIN + 32'h1;
				endcase
			end
		endcase
	endfunction

	function automatic point_cmd_t mk_cmd(logic [CMD_W-1:0] cmd, logic [31:0] x,
			logic [31:0] y, logic [31:0] z, logic [31:0] mx, logic [31:0] my,
			logic [31:0] mz);
		point_cmd_t c;
		c.command = cmd;
		c.in_x = x;
		c.in_y = y;
		c.in_z = z;
		c.box_max_x = mx;
		c.box_max_y = my;
		c.box_max_z = mz;
		return c;
	endfunction

	function automatic point_cmd_t random_cmd();
		point_cmd_t c;
		logic [31:0] lo [3];
		logic [31:0] hi [3];
		logic [31:0] tmp;
		if ($urandom_range(1, 20) == 1)
			c.command = CMD_W'($urandom_range(CMD_BOX + 1, (1 << CMD_W) - 1));
		else
			c.command = CMD_W'($urandom_range(CMD_XFORM, CMD_BOX));
		for (int k = 0; k < 3; k++) begin
			lo[k] = pick_word(VAL_MIXED);
			hi[k] = pick_word(VAL_MIXED);
			// Most boxes come in ordered; about one in five keeps whatever
			// order the draw gave, which inverts some axes.
			if (c.command == CMD_BOX && $urandom_range(1, 5) != 1 &&
					$signed(lo[k]) > $signed(hi[k])) begin
				tmp = lo[k];
				lo[k] = hi[k];
				hi[k] = tmp;
			end
		end
		c.in_x = lo[0];
		c.in_y = lo[1];
		c.in_z = lo[2];
		c.box_max_x = hi[0];
		c.box_max_y = hi[1];
		c.box_max_z = hi[2];
		return c;
	endfunction

	// Every rotation entry set to one value, every origin entry to another.
	function automatic cfg_regs_t fill_matrix(logic [31:0] rot, logic [31:0] org);
		cfg_regs_t m;
		for (int row = 0; row < 3; row++) begin
			m[row * 2] = {rot, rot};
			m[row * 2 + 1] = {org, rot};
		end
		return m;
	endfunction

	function automatic cfg_regs_t make_matrix(value_kind_e kind);
		cfg_regs_t m;
		for (int row = 0; row < 3; row++) begin
			m[row * 2] = {pick_word(kind), pick_word(kind)};
			m[row * 2 + 1] = {pick_word(kind), pick_word(kind)};
		end
		return m;
	endfunction

	function automatic int pick_idle_pct();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 10;
			2: return 30;
			default: return 60;
		endcase
	endfunction

	// Sends one command beat, possibly after a pause, and records the
	// expected result once the beat is accepted. It is entered and left on a
	// rising edge; valid stays high on the way out so that the next beat can
	// follow directly.
	task automatic send_cmd(input point_cmd_t c);
		if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_data <= c;
		do @(posedge clk); while (!cmd_ready);
		pending_results.push_back(predict_point(c));
	endtask

	// Lowers valid and waits until every expected result has been taken, so
	// that nothing is in flight inside the block.
	task automatic drain_results();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Writes all six registers, one per cycle, while the block is idle.
	task automatic load_matrix(input cfg_regs_t m);
		for (int k = 0; k < CFG_REGS; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= cfg_reg_e'(k);
			cfg_wdata <= m[k];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		matrix_regs = m;
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	// Prints one line per mismatch up to a cap, and counts every one.
	task automatic report_mismatch(input string what);
		if (mismatch_count < PRINT_CAP)
			$display("[%0t] mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
	endtask

	// Each accepted result beat is checked against the oldest expectation.
	always @(posedge clk) begin : check_results
		point_res_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result beat with no command outstanding");
			end else begin
				want = pending_results.pop_front();
				compare_field("res_x", res_data.res_x, want.res_x);
				compare_field("res_y", res_data.res_y, want.res_y);
				compare_field("res_z", res_data.res_z, want.res_z);
				compare_field("world_max_x", res_data.world_max_x, want.world_max_x);
				compare_field("world_max_y", res_data.world_max_y, want.world_max_y);
				compare_field("world_max_z", res_data.world_max_z, want.world_max_z);
				compare_field("saturated", 32'(res_data.saturated), 32'(want.saturated));
			end
		end
	end

	// The receiver stalls in random bursts; with stall_pct at zero it keeps
	// res_ready high on every cycle.
	initial begin
		forever begin
			@(posedge clk);
			if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
				res_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			res_ready <= 1'b1;
		end
	end

	// A run in which no beat moves on either channel for too long has hung.
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && cmd_ready) || (res_valid && res_ready) || cfg_we) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STALL_LIMIT) begin
				$display("affine_point_transform_top regression: fail");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Every command under the identity matrix that reset loads, followed by
	// the three unused command codes.
	task automatic test_reset_identity();
		matrix_regs = '0;
		matrix_regs[REG_ROW0_LO][31:0] = Q_ONE;
		matrix_regs[REG_ROW1_LO][63:32] = Q_ONE;
		matrix_regs[REG_ROW2_HI][31:0] = Q_ONE;
		// 1.5, -2.25 and 3.0; the box maximum fields carry junk that only
		// the box command may look at.
		send_cmd(mk_cmd(CMD_XFORM, 32'h0001_8000, 32'hFFFD_C000, 32'h0003_0000,
			W_MAX, W_MIN, 32'h1234_5678));
		send_cmd(mk_cmd(CMD_INV_XFORM, 32'h0001_8000, 32'hFFFD_C000, 32'h0003_0000,
			W_MAX, W_MIN, 32'h1234_5678));
		send_cmd(mk_cmd(CMD_ROTATE, 32'h0001_8000, 32'hFFFD_C000, 32'h0003_0000,
			W_MAX, W_MIN, 32'h1234_5678));
		send_cmd(mk_cmd(CMD_INV_ROTATE, 32'h0001_8000, 32'hFFFD_C000, 32'h0003_0000,
			W_MAX, W_MIN, 32'h1234_5678));
		// An ordinary box, then an inverted one whose odd sum rounds down.
		send_cmd(mk_cmd(CMD_BOX, -Q_ONE, -(Q_ONE * 2), -(Q_ONE * 3),
			Q_ONE * 4, Q_ONE * 5, Q_ONE * 6));
		send_cmd(mk_cmd(CMD_BOX, 32'h1, Q_ONE * 2, 32'h0,
			32'hFFFF_FFFC, -(Q_ONE * 2), 32'hFFFF_FFFF));
		for (int k = CMD_BOX + 1; k < (1 << CMD_W); k++)
			send_cmd(mk_cmd(CMD_W'(k), W_MAX, W_MIN, Q_ONE, W_MAX, W_MIN, Q_ONE));
	endtask

	// Corner vectors and boxes that drive the sums and the saturation logic
	// as hard as they go.
	task automatic send_edge_set();
		send_cmd(mk_cmd(CMD_XFORM, W_MAX, W_MAX, W_MAX, 32'h0, 32'h0, 32'h0));
		send_cmd(mk_cmd(CMD_XFORM, W_MIN, W_MIN, W_MIN, 32'h0, 32'h0, 32'h0));
		send_cmd(mk_cmd(CMD_INV_XFORM, W_MIN, W_MIN, W_MIN, 32'h0, 32'h0, 32'h0));
		send_cmd(mk_cmd(CMD_INV_XFORM, W_MAX, W_MAX, W_MAX, 32'h0, 32'h0, 32'h0));
		send_cmd(mk_cmd(CMD_ROTATE, W_MAX, W_MIN, 32'h1, 32'h0, 32'h0, 32'h0));
		send_cmd(mk_cmd(CMD_INV_ROTATE, W_MIN, W_MAX, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
		send_cmd(mk_cmd(CMD_BOX, W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, W_MAX));
		send_cmd(mk_cmd(CMD_BOX, W_MAX, W_MAX, W_MAX, W_MIN, W_MIN, W_MIN));
	endtask

	task automatic test_matrix_extremes();
		drain_results();
		load_matrix(fill_matrix(W_MAX, W_MIN));
		send_edge_set();
		drain_results();
		load_matrix(fill_matrix(W_MIN, W_MAX));
		send_edge_set();
	endtask

	// Several random matrices, each with its own idle pattern on both sides,
	// and a stream of random commands under each.
	task automatic test_random_matrices();
		for (int phase = 0; phase < PHASES; phase++) begin
			drain_results();
			load_matrix(make_matrix(value_kind_e'(phase % 4)));
			gap_pct = pick_idle_pct();
			stall_pct = pick_idle_pct();
			repeat (PHASE_BEATS) send_cmd(random_cmd());
		end
	endtask

	// The closing stretch runs at full rate with no pauses and no stalls.
	// Stalls are switched off before the drain, so none is still running
	// once the last stream starts.
	task automatic test_full_rate();
		gap_pct = 0;
		stall_pct = 0;
		drain_results();
		load_matrix(make_matrix(VAL_MIXED));
		repeat (FINAL_BEATS) send_cmd(random_cmd());
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_identity();
		test_matrix_extremes();
		test_random_matrices();
		test_full_rate();
		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("affine_point_transform_top regression: pass");
		else
			$display("affine_point_transform_top regression: fail");
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/apt_pkg.sv
hdl/apt_prep.sv
hdl/apt_mul.sv
hdl/apt_acc.sv
hdl/apt_obuf.sv
hdl/affine_point_transform_top.sv
test/affine_point_transform_top_tb.sv
